// ===== src/tbgc_pkg.sv =====
// Shared types and constants for the two-button gesture classifier.
// No dependencies.
package tbgc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned DurW  = 16;
  localparam int unsigned CfgW  = 32;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [TimeW-1:0] time_ms_t;
  typedef logic [DurW-1:0]  dur_ms_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STARTUP_UNTIL = 2'd0,
    CFG_HOLD_TIME     = 2'd1,
    CFG_LOCKOUT_TIME  = 2'd2
  } cfg_idx_t;

  localparam time_ms_t StartupRst = 32'd0;
  localparam dur_ms_t  HoldRst    = 16'd5000;
  localparam dur_ms_t  LockoutRst = 16'd500;

  // wrap-safe "now has reached t": sign bit of now - t is clear
  function automatic logic is_due(input time_ms_t now, input time_ms_t t);
    time_ms_t d;
    d = now - t;
    return ~d[TimeW-1];
  endfunction

endpackage

// ===== src/two_button_gesture_classifier.sv =====
// Two-button gesture classifier, top level.
// Depends on tbgc_pkg for types, reset values and the time compare.
//
// Takes one button sample per clock while the result side keeps up: a sample is
// captured in an input register, classified against the gesture state and written
// to the result register once that register can take it. The only loop is the
// gesture state update (one 32-bit add of start and hold time followed by the
// wrap-safe compare). Configuration takes effect on the next sample; write it
// only while no sample is in flight.
module two_button_gesture_classifier
  import tbgc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgW-1:0]      cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [TimeW-1:0]     in_now_ms,
  input  logic                 in_button_a,
  input  logic                 in_button_b,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_activity,
  output logic                 out_calibrate,
  output logic                 out_measure,
  output logic                 out_toggle_ref,
  output logic                 out_reference_mode
);

  // configuration
  time_ms_t startup_until_r;
  dur_ms_t  hold_time_r;
  dur_ms_t  lockout_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      startup_until_r <= StartupRst;
      hold_time_r     <= HoldRst;
      lockout_time_r  <= LockoutRst;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STARTUP_UNTIL: startup_until_r <= cfg_wdata;
        CFG_HOLD_TIME:     hold_time_r     <= cfg_wdata[DurW-1:0];
        CFG_LOCKOUT_TIME:  lockout_time_r  <= cfg_wdata[DurW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic     s1_valid_r;
  time_ms_t s1_now_r;
  logic     s1_a_r;
  logic     s1_b_r;
  logic     s1_adv;
  logic     s1_fire;

  assign s1_adv   = !out_valid || out_ready;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_now_r <= in_now_ms;
      s1_a_r   <= in_button_a;
      s1_b_r   <= in_button_b;
    end
  end

  // gesture state
  logic     a_was_down_r, b_was_down_r, chord_active_r, chord_fired_r;
  logic     a_hold_fired_r, b_hold_fired_r, ref_mode_r;
  time_ms_t chord_start_r, a_start_r, b_start_r, lockout_until_r;

  logic     chord_active_nxt, chord_fired_nxt, a_hold_fired_nxt, b_hold_fired_nxt;
  logic     ref_mode_nxt;
  time_ms_t chord_start_nxt, a_start_nxt, b_start_nxt, lockout_until_nxt;
  logic     act, cal, meas, tog;
  time_ms_t lock_end;
  time_ms_t hold_ext;

  assign lock_end = s1_now_r + {{(TimeW-DurW){1'b0}}, lockout_time_r};
  assign hold_ext = {{(TimeW-DurW){1'b0}}, hold_time_r};

  always_comb begin
    chord_active_nxt  = chord_active_r;
    chord_fired_nxt   = chord_fired_r;
    a_hold_fired_nxt  = a_hold_fired_r;
    b_hold_fired_nxt  = b_hold_fired_r;
    ref_mode_nxt      = ref_mode_r;
    chord_start_nxt   = chord_start_r;
    a_start_nxt       = a_start_r;
    b_start_nxt       = b_start_r;
    lockout_until_nxt = lockout_until_r;
    cal  = 1'b0;
    meas = 1'b0;
    tog  = 1'b0;
    act  = (s1_a_r && !a_was_down_r) || (s1_b_r && !b_was_down_r);

    priority if (!is_due(s1_now_r, startup_until_r) ||
                 !is_due(s1_now_r, lockout_until_r)) begin
      // blocked: only the levels move
    end else if (s1_a_r && s1_b_r) begin
      if (!chord_active_r) begin
        chord_start_nxt = s1_now_r;
        chord_fired_nxt = 1'b0;
      end
      chord_active_nxt = 1'b1;
      if (!chord_fired_nxt && is_due(s1_now_r, chord_start_nxt + hold_ext)) begin
        chord_fired_nxt   = 1'b1;
        a_hold_fired_nxt  = 1'b1;
        b_hold_fired_nxt  = 1'b1;
        lockout_until_nxt = lock_end;
        cal               = 1'b1;
      end
    end else if (chord_active_r) begin
      if (!s1_a_r && !s1_b_r) begin
        chord_active_nxt = 1'b0;
        chord_fired_nxt  = 1'b0;
      end
    end else begin
      if (s1_a_r && !a_was_down_r) begin
        a_start_nxt      = s1_now_r;
        a_hold_fired_nxt = 1'b0;
      end
      if (s1_b_r && !b_was_down_r) begin
        b_start_nxt      = s1_now_r;
        b_hold_fired_nxt = 1'b0;
      end
      priority if (s1_a_r && !a_hold_fired_nxt &&
                   is_due(s1_now_r, a_start_nxt + hold_ext)) begin
        a_hold_fired_nxt  = 1'b1;
        lockout_until_nxt = lock_end;
      end else if (s1_b_r && !b_hold_fired_nxt &&
                   is_due(s1_now_r, b_start_nxt + hold_ext)) begin
        b_hold_fired_nxt  = 1'b1;
        lockout_until_nxt = lock_end;
      end else begin
        if (!s1_a_r && a_was_down_r && !a_hold_fired_nxt && !s1_b_r) begin
          meas              = 1'b1;
          lockout_until_nxt = lock_end;
        end
        if (!s1_b_r && b_was_down_r && !b_hold_fired_nxt && !s1_a_r) begin
          tog               = 1'b1;
          ref_mode_nxt      = !ref_mode_r;
          lockout_until_nxt = lock_end;
        end
      end
    end

    if (cal || meas || tog) begin
      act = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_was_down_r    <= 1'b0;
      b_was_down_r    <= 1'b0;
      chord_active_r  <= 1'b0;
      chord_fired_r   <= 1'b0;
      a_hold_fired_r  <= 1'b0;
      b_hold_fired_r  <= 1'b0;
      ref_mode_r      <= 1'b0;
      chord_start_r   <= '0;
      a_start_r       <= '0;
      b_start_r       <= '0;
      lockout_until_r <= '0;
    end else if (s1_fire) begin
      a_was_down_r    <= s1_a_r;
      b_was_down_r    <= s1_b_r;
      chord_active_r  <= chord_active_nxt;
      chord_fired_r   <= chord_fired_nxt;
      a_hold_fired_r  <= a_hold_fired_nxt;
      b_hold_fired_r  <= b_hold_fired_nxt;
      ref_mode_r      <= ref_mode_nxt;
      chord_start_r   <= chord_start_nxt;
      a_start_r       <= a_start_nxt;
      b_start_r       <= b_start_nxt;
      lockout_until_r <= lockout_until_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_activity       <= act;
      out_calibrate      <= cal;
      out_measure        <= meas;
      out_toggle_ref     <= tog;
      out_reference_mode <= ref_mode_nxt;
    end
  end

  // checks
  a_cal_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_calibrate |-> out_activity && !out_measure && !out_toggle_ref)
    else $error("calibrate reported with measure/toggle or without activity");

  a_tog_flip: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && tog |=> ref_mode_r != $past(ref_mode_r))
    else $error("toggle did not flip reference mode");

  a_cal_state: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && cal |=> chord_fired_r && chord_active_r && a_hold_fired_r && b_hold_fired_r)
    else $error("calibrate without chord state update");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid && !out_ready |-> !in_ready)
    else $error("input taken while both stages are full and stalled");

  a_mode_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_reference_mode == ref_mode_r)
    else $error("reported reference mode differs from state");

endmodule

// ===== dv/tb_two_button_gesture_classifier.sv =====
// Testbench for two_button_gesture_classifier: directed gesture table, then random gestures.
// Results are checked against an in-bench predictor under several configs and idle patterns.
// Depends on tbgc_pkg and the RTL top level only.
module tb_two_button_gesture_classifier;
  import tbgc_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned Settle     = 8;
  localparam int unsigned NumDir     = 22;
  localparam int unsigned PhaseItems = 450;
  localparam int unsigned PrintCap   = 50;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  typedef struct packed {
    logic activity;
    logic calibrate;
    logic measure;
    logic toggle_ref;
    logic reference_mode;
  } gesture_res_t;

  typedef struct packed {
    time_ms_t     now;
    logic         a;
    logic         b;
    logic         typed;
    gesture_res_t res;
  } sample_row_t;

  typedef enum logic [2:0] {
    GEST_SOLO_A,
    GEST_SOLO_B,
    GEST_CHORD,
    GEST_BLOCKED_PAIR,
    GEST_NOISE
  } gesture_t;

  // reset config; rows without a typed result go through the predictor
  localparam sample_row_t DirRows [NumDir] = '{
    '{32'd100,        1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{32'd200,        1'b1, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{32'd300,        1'b0, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{32'd400,        1'b0, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{32'd900,        1'b0, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{32'd1500,       1'b0, 1'b1, 1'b0, '0},
    '{32'd6500,       1'b0, 1'b1, 1'b0, '0},  // B alone reaches hold: lockout only
    '{32'd7000,       1'b0, 1'b0, 1'b0, '0},
    '{32'd8000,       1'b1, 1'b1, 1'b0, '0},
    '{32'd13000,      1'b1, 1'b1, 1'b0, '0},  // chord hold completes
    '{32'd13600,      1'b1, 1'b1, 1'b0, '0},
    '{32'd13700,      1'b1, 1'b0, 1'b0, '0},
    '{32'd13800,      1'b0, 1'b0, 1'b0, '0},
    '{32'd14000,      1'b1, 1'b0, 1'b0, '0},
    '{32'd14100,      1'b0, 1'b0, 1'b0, '0},
    '{32'd15000,      1'b0, 1'b1, 1'b0, '0},
    '{32'd15100,      1'b0, 1'b0, 1'b0, '0},
    '{32'd15200,      1'b1, 1'b1, 1'b0, '0},  // both pressed inside lockout
    '{32'd15700,      1'b0, 1'b0, 1'b0, '0},  // both released: measure and toggle
    '{32'hFFFF_FFFF,  1'b1, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{32'h8000_0000,  1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{32'h7FFF_FFFF,  1'b0, 1'b0, 1'b0, '0}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [TimeW-1:0]   in_now_ms = '0;
  logic               in_button_a = 1'b0;
  logic               in_button_b = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_activity;
  logic               out_calibrate;
  logic               out_measure;
  logic               out_toggle_ref;
  logic               out_reference_mode;

  // typed expectation riding along with the payload
  logic               row_typed = 1'b0;
  gesture_res_t       row_res = '0;

  gesture_res_t       gesture_got;
  gesture_res_t       gesture_want;
  gesture_res_t       expected_gestures [$];

  int unsigned        cycle_count = 0;
  int unsigned        samples_sent = 0;
  int unsigned        results_seen = 0;
  int unsigned        mismatch_count = 0;
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_stall_pct = 0;
  time_ms_t           cur_ms;

  // predictor config and state
  time_ms_t           cfg_startup;
  dur_ms_t            cfg_hold;
  dur_ms_t            cfg_lockout;
  logic               prev_a, prev_b;
  logic               chord_on, chord_done;
  logic               hold_done_a, hold_done_b;
  time_ms_t           chord_t0, press_t0_a, press_t0_b;
  time_ms_t           quiet_until;
  logic               body_ref;

  two_button_gesture_classifier i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_now_ms          (in_now_ms),
    .in_button_a        (in_button_a),
    .in_button_b        (in_button_b),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_activity       (out_activity),
    .out_calibrate      (out_calibrate),
    .out_measure        (out_measure),
    .out_toggle_ref     (out_toggle_ref),
    .out_reference_mode (out_reference_mode)
  );

  assign gesture_got = {out_activity, out_calibrate, out_measure, out_toggle_ref,
                        out_reference_mode};

  always #5 clk = ~clk;

  function automatic logic reached(time_ms_t now, time_ms_t t);
    time_ms_t d;
    d = now - t;
    return !d[TimeW-1];
  endfunction

  task automatic clear_model();
    cfg_startup = StartupRst;
    cfg_hold    = HoldRst;
    cfg_lockout = LockoutRst;
    prev_a      = 1'b0;
    prev_b      = 1'b0;
    chord_on    = 1'b0;
    chord_done  = 1'b0;
    hold_done_a = 1'b0;
    hold_done_b = 1'b0;
    chord_t0    = '0;
    press_t0_a  = '0;
    press_t0_b  = '0;
    quiet_until = '0;
    body_ref    = 1'b0;
  endtask

  function automatic gesture_res_t classify_sample(time_ms_t now, logic a, logic b);
    gesture_res_t r;
    r = '0;
    r.activity = (a && !prev_a) || (b && !prev_b);
    // outside startup and lockout; otherwise only the levels move
    if (reached(now, cfg_startup) && reached(now, quiet_until)) begin
      if (a && b) begin
        if (!chord_on) begin
          chord_t0   = now;
          chord_done = 1'b0;
        end
        chord_on = 1'b1;
        if (!chord_done && reached(now, chord_t0 + cfg_hold)) begin
          chord_done  = 1'b1;
          hold_done_a = 1'b1;
          hold_done_b = 1'b1;
          quiet_until = now + cfg_lockout;
          r.calibrate = 1'b1;
        end
      end else if (chord_on) begin
        if (!a && !b) begin
          chord_on   = 1'b0;
          chord_done = 1'b0;
        end
      end else begin
        if (a && !prev_a) begin
          press_t0_a  = now;
          hold_done_a = 1'b0;
        end
        if (b && !prev_b) begin
          press_t0_b  = now;
          hold_done_b = 1'b0;
        end
        if (a && !hold_done_a && reached(now, press_t0_a + cfg_hold)) begin
          hold_done_a = 1'b1;
          quiet_until = now + cfg_lockout;
        end else if (b && !hold_done_b && reached(now, press_t0_b + cfg_hold)) begin
          hold_done_b = 1'b1;
          quiet_until = now + cfg_lockout;
        end else begin
          if (!a && prev_a && !hold_done_a && !b) begin
            r.measure   = 1'b1;
            quiet_until = now + cfg_lockout;
          end
          if (!b && prev_b && !hold_done_b && !a) begin
            r.toggle_ref = 1'b1;
            body_ref     = !body_ref;
            quiet_until  = now + cfg_lockout;
          end
        end
      end
    end
    prev_a = a;
    prev_b = b;
    if (r.calibrate || r.measure || r.toggle_ref) begin
      r.activity = 1'b1;
    end
    r.reference_mode = body_ref;
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatch_count < PrintCap) begin
      $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic check_gesture(gesture_res_t got, gesture_res_t want);
    if (got.activity !== want.activity) begin
      report_mismatch("activity", got.activity, want.activity);
    end
    if (got.calibrate !== want.calibrate) begin
      report_mismatch("calibrate", got.calibrate, want.calibrate);
    end
    if (got.measure !== want.measure) begin
      report_mismatch("measure", got.measure, want.measure);
    end
    if (got.toggle_ref !== want.toggle_ref) begin
      report_mismatch("toggle_ref", got.toggle_ref, want.toggle_ref);
    end
    if (got.reference_mode !== want.reference_mode) begin
      report_mismatch("reference_mode", got.reference_mode, want.reference_mode);
    end
  endtask

  // both transfers are seen at the same edge: the prediction is queued before the check
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        gesture_want = classify_sample(in_now_ms, in_button_a, in_button_b);
        if (row_typed) begin
          gesture_want = row_res;
        end
        expected_gestures.push_back(gesture_want);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_gestures.size() == 0) begin
          report_mismatch("result with nothing pending", 1, 0);
        end else begin
          check_gesture(gesture_got, expected_gestures.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_sample(time_ms_t t, logic a, logic b, logic typed, gesture_res_t res);
    in_valid    <= 1'b1;
    in_now_ms   <= t;
    in_button_a <= a;
    in_button_b <= b;
    row_typed   <= typed;
    row_res     <= res;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    samples_sent++;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid    <= 1'b0;
      in_now_ms   <= $urandom;
      in_button_a <= 1'($urandom);
      in_button_b <= 1'($urandom);
      do begin
        @(posedge clk);
      end while ($urandom_range(0, 99) < send_idle_pct);
    end
  endtask

  // counts are compared so that a transfer at this very edge is never missed
  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (results_seen < samples_sent || expected_gestures.size() != 0) begin
      @(posedge clk);
    end
    repeat (Settle) @(posedge clk);
  endtask

  // upper bits of the short registers carry junk that must be dropped
  task automatic load_config(time_ms_t startup, dur_ms_t hold, dur_ms_t lockout);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STARTUP_UNTIL;
    cfg_wdata <= startup;
    @(posedge clk);
    cfg_index <= CFG_HOLD_TIME;
    cfg_wdata <= {16'($urandom), hold};
    @(posedge clk);
    cfg_index <= CFG_LOCKOUT_TIME;
    cfg_wdata <= {16'($urandom), lockout};
    @(posedge clk);
    cfg_index <= CfgIdxSpare;
    cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_we      <= 1'b0;
    cfg_startup = startup;
    cfg_hold    = hold;
    cfg_lockout = lockout;
  endtask

  // press lengths cluster on the hold boundary
  function automatic int unsigned pick_duration();
    int unsigned h;
    h = cfg_hold;
    case ($urandom_range(0, 4))
      0: return (h == 0) ? 0 : h - 1;
      1: return h;
      2: return h + 1;
      3: return $urandom_range(0, h);
      default: return h + $urandom_range(0, h);
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned lk;
    lk = cfg_lockout;
    case ($urandom_range(0, 2))
      0: return lk + $urandom_range(0, 2);
      1: return $urandom_range(0, lk);
      default: return $urandom_range(0, 2 * cfg_hold + 10);
    endcase
  endfunction

  task automatic hold_levels(logic a, logic b, int unsigned dur);
    int unsigned left;
    int unsigned step;
    left = dur;
    send_sample(cur_ms, a, b, 1'b0, '0);
    repeat ($urandom_range(0, 3)) begin
      step   = $urandom_range(0, left);
      cur_ms += step;
      left   -= step;
      send_sample(cur_ms, a, b, 1'b0, '0);
    end
    cur_ms += left;
    send_sample(cur_ms, a, b, 1'b0, '0);
  endtask

  task automatic play_gesture();
    gesture_t    kind;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    kind = (roll < 25) ? GEST_SOLO_A : (roll < 50) ? GEST_SOLO_B :
           (roll < 75) ? GEST_CHORD : (roll < 87) ? GEST_BLOCKED_PAIR : GEST_NOISE;
    case (kind)
      GEST_SOLO_A: begin
        hold_levels(1'b1, 1'b0, pick_duration());
        cur_ms += $urandom_range(0, 3);
        send_sample(cur_ms, 1'b0, 1'b0, 1'b0, '0);
      end
      GEST_SOLO_B: begin
        hold_levels(1'b0, 1'b1, pick_duration());
        cur_ms += $urandom_range(0, 3);
        send_sample(cur_ms, 1'b0, 1'b0, 1'b0, '0);
      end
      GEST_CHORD: begin
        roll = $urandom_range(0, 2);
        if (roll != 0) begin
          send_sample(cur_ms, roll == 1, roll == 2, 1'b0, '0);
          cur_ms += $urandom_range(0, 3);
        end
        hold_levels(1'b1, 1'b1, pick_duration());
        cur_ms += $urandom_range(0, 3);
        roll = $urandom_range(0, 2);
        if (roll != 0) begin
          send_sample(cur_ms, roll == 1, roll == 2, 1'b0, '0);
          cur_ms += $urandom_range(0, 3);
        end
        send_sample(cur_ms, 1'b0, 1'b0, 1'b0, '0);
      end
      GEST_BLOCKED_PAIR: begin
        // quick A opens a lockout, both go down inside it and up after it
        send_sample(cur_ms, 1'b1, 1'b0, 1'b0, '0);
        cur_ms += $urandom_range(0, 2);
        send_sample(cur_ms, 1'b0, 1'b0, 1'b0, '0);
        cur_ms += $urandom_range(0, cfg_lockout);
        send_sample(cur_ms, 1'b1, 1'b1, 1'b0, '0);
        cur_ms += cfg_lockout + $urandom_range(0, 2);
        send_sample(cur_ms, 1'b0, 1'b0, 1'b0, '0);
      end
      default: begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 2))
            0: cur_ms = $urandom;
            1: cur_ms = 32'hFFFF_FFFF - $urandom_range(0, 100);
            default: cur_ms += $urandom_range(0, 50);
          endcase
          send_sample(cur_ms, 1'($urandom), 1'($urandom), 1'b0, '0);
        end
      end
    endcase
    cur_ms += pick_gap();
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct, time_ms_t startup,
                           dur_ms_t hold, dur_ms_t lockout);
    int unsigned goal;
    logic        paused;
    goal   = samples_sent + PhaseItems;
    paused = 1'b0;
    wait_results_done();
    load_config(startup, hold, lockout);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (samples_sent < goal) begin
      // sender holds off mid-phase until everything has drained
      if (!paused && samples_sent >= goal - PhaseItems / 2) begin
        wait_results_done();
        paused = 1'b1;
      end
      play_gesture();
    end
  endtask

  initial begin
    clear_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NumDir; i++) begin
      send_sample(DirRows[i].now, DirRows[i].a, DirRows[i].b, DirRows[i].typed,
                  DirRows[i].res);
    end

    cur_ms = 32'd20000;
    run_phase(0, 0, 32'd0, 16'd1, 16'd0);
    run_phase(88, 0, cur_ms + 32'd200, 16'd20, 16'hFFFF);
    run_phase(0, 88, 32'hFFFF_FFFF, 16'hFFFF, 16'd10);
    run_phase(16, 16, cur_ms + 32'($urandom_range(0, 50)), 16'd0, 16'd5);
    wait_results_done();

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/tbgc_pkg.sv
src/two_button_gesture_classifier.sv
dv/tb_two_button_gesture_classifier.sv
